/* rtl/core/xob64_pkg.sv */
`default_nettype none

package xob64_pkg;

  // Obfuscation mask: ~b ^ 0xAA equals b ^ 0x55
  localparam logic [7:0] OBF_MASK = 8'hAA;
  localparam logic [7:0] PAD_CHAR = 8'h3D;  // '='

  // Default depth of the request queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // Characters per request
  localparam int unsigned CHARS_PER_REQ = 4;

  // Position of the next byte inside its 3-byte group
  localparam logic [1:0] PH_0 = 2'd0;
  localparam logic [1:0] PH_1 = 2'd1;
  localparam logic [1:0] PH_2 = 2'd2;
  localparam logic [1:0] PH_3 = 2'd3;  // never reached, handled as PH_0

  // One request for the back end: up to four ready-made characters
  typedef struct packed {
    logic [CHARS_PER_REQ-1:0][7:0] chars;
    logic [1:0]                    last_idx;
    logic                          final_flag;
  } xob64_req_t;

  // Front end state, exported for checking
  typedef struct packed {
    logic [1:0] phase;
    logic [3:0] held;
  } xob64_sts_t;

  // Sextet to Base64 ASCII, standard alphabet
  function automatic logic [7:0] b64_char(input logic [5:0] v);
    logic [7:0] c;
    c = {2'b00, v};
    if (v < 6'd26) begin
      return 8'h41 + c;
    end else if (v < 6'd52) begin
      return 8'h47 + c;
    end else if (v < 6'd62) begin
      return c - 8'd4;
    end else if (v == 6'd62) begin
      return 8'h2B;
    end else begin
      return 8'h2F;
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/core/xob64_ifs.sv */
`default_nettype none

// Byte channel into the encoder
interface xob64_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

// Character channel out of the encoder
interface xob64_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_char;
  logic       final_char;

  modport source (output valid, output out_char, output final_char, input ready);
  modport sink   (input valid, input out_char, input final_char, output ready);
endinterface

`default_nettype wire

/* rtl/core/xob64_front.sv */
`default_nettype none

module xob64_front
  import xob64_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  xob64_in_if.sink     in_if,
  input  wire logic    q_full,
  output logic         push,
  output xob64_req_t   req,
  output xob64_sts_t   sts
);

  logic [1:0] phase_r, phase_nxt;
  logic [3:0] held_r,  held_nxt;
  logic [1:0] ph_a;
  logic [3:0] held_a;
  logic [7:0] obf;
  logic       accept;

  assign in_if.ready = !q_full;
  assign accept      = in_if.valid && !q_full;
  assign push        = accept;
  assign sts         = '{phase: phase_r, held: held_r};

  // Classify the byte against the group phase and build its character request
  always_comb begin
    obf            = ~in_if.data_byte ^ OBF_MASK;
    req.chars      = {CHARS_PER_REQ{PAD_CHAR}};
    req.last_idx   = 2'd0;
    req.final_flag = in_if.final_byte;
    ph_a           = PH_0;
    held_a         = 4'd0;

    unique case (phase_r)
      PH_1: begin
        req.chars[0] = b64_char({held_r[1:0], obf[7:4]});
        held_a       = obf[3:0];
        ph_a         = PH_2;
      end
      PH_2: begin
        req.chars[0] = b64_char({held_r, obf[7:6]});
        req.chars[1] = b64_char(obf[5:0]);
        req.last_idx = 2'd1;
        held_a       = 4'd0;
        ph_a         = PH_0;
      end
      PH_0, PH_3: begin
        req.chars[0] = b64_char(obf[7:2]);
        held_a       = {2'b00, obf[1:0]};
        ph_a         = PH_1;
      end
    endcase

    // Flush leftover bits and pad to a full group on the last byte
    if (in_if.final_byte) begin
      unique case (ph_a)
        PH_1: begin
          req.chars[1] = b64_char({held_a[1:0], 4'b0000});
          req.last_idx = 2'd3;
        end
        PH_2: begin
          req.chars[1] = b64_char({held_a, 2'b00});
          req.last_idx = 2'd2;
        end
        PH_0, PH_3: begin
        end
      endcase
      phase_nxt = PH_0;
      held_nxt  = 4'd0;
    end else begin
      phase_nxt = ph_a;
      held_nxt  = held_a;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_0;
      held_r  <= 4'd0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/xob64_fifo.sv */
`default_nettype none

module xob64_fifo
  import xob64_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire xob64_req_t  push_req,
  output logic             full,
  input  wire logic        pop,
  output logic             not_empty,
  output xob64_req_t       pop_req
);

  localparam int unsigned AW = $clog2(DEPTH);

  xob64_req_t    slot_r [DEPTH];
  logic [AW:0]   wr_ptr_r, rd_ptr_r;

  assign full      = (wr_ptr_r[AW] != rd_ptr_r[AW]) &&
                     (wr_ptr_r[AW-1:0] == rd_ptr_r[AW-1:0]);
  assign not_empty = (wr_ptr_r != rd_ptr_r);
  assign pop_req   = slot_r[rd_ptr_r[AW-1:0]];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r[AW-1:0]] <= push_req;
    end
  end

  // Pointers, one wrap bit above the index
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/xob64_back.sv */
`default_nettype none

module xob64_back
  import xob64_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  input  wire xob64_req_t  q_req,
  output logic             pop,
  xob64_out_if.source      out_if
);

  xob64_req_t cur_r;
  logic       cur_valid_r, cur_valid_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r;
  logic [7:0] out_char_r;
  logic       final_char_r;
  logic       out_load, emit, cur_done;

  assign out_load = !out_valid_r || out_if.ready;
  assign emit     = out_load && cur_valid_r;
  assign cur_done = emit && (idx_r == cur_r.last_idx);
  assign pop      = q_valid && (!cur_valid_r || cur_done);

  assign out_if.valid      = out_valid_r;
  assign out_if.out_char   = out_char_r;
  assign out_if.final_char = final_char_r;

  // Walk the current request one character per cycle while the output is not stalled
  always_comb begin
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    if (pop) begin
      cur_valid_nxt = 1'b1;
      idx_nxt       = 2'd0;
    end else if (cur_done) begin
      cur_valid_nxt = 1'b0;
    end else if (emit) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
      if (out_load) out_valid_r <= cur_valid_r;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (pop) cur_r <= q_req;
    if (emit) begin
      out_char_r   <= cur_r.chars[idx_r];
      final_char_r <= cur_r.final_flag && (idx_r == cur_r.last_idx);
    end
  end

endmodule

`default_nettype wire

/* rtl/core/xor_obfuscate_base64_encoder.sv */
// Channel  Direction  Payload                  Handshake
// in_if    input      data_byte[7:0], final_byte  valid/ready
// out_if   output     out_char[7:0], final_char   valid/ready
//
// Each byte accepted while the queue is not full becomes one request of 1 to 4 characters.
// The back end gives one character per cycle while out_if is ready, and a long message
// averages four characters per three bytes; the output character rate sets the pace.
// A byte's characters pass the queue slot, the current request and the output register.
// Reset is synchronous, active low, and empties the queue and the output register.
// Input and output stall independently; the queue holds QUEUE_DEPTH requests.
`default_nettype none

module xor_obfuscate_base64_encoder
  import xob64_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  xob64_in_if.sink     in_if,
  xob64_out_if.source  out_if
);

  xob64_req_t push_req, pop_req;
  xob64_sts_t front_sts;
  logic       push, q_full, q_valid, pop;

  xob64_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_if (in_if),
    .q_full(q_full),
    .push  (push),
    .req   (push_req),
    .sts   (front_sts)
  );

  xob64_fifo #(
    .DEPTH(QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_req (push_req),
    .full     (q_full),
    .pop      (pop),
    .not_empty(q_valid),
    .pop_req  (pop_req)
  );

  xob64_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_valid(q_valid),
    .q_req  (pop_req),
    .pop    (pop),
    .out_if (out_if)
  );

`ifndef SYNTH
  // Output register is empty right after reset
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_if.valid)
    else $error("output valid after reset");

  // A final byte returns the group to its start
  a_final_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready && in_if.final_byte) |=> (front_sts.phase == PH_0))
    else $error("phase not cleared after final byte");

  // No leftover bits at the start of a group
  a_phase0_held: assert property (@(posedge clk) disable iff (!rst_n)
    (front_sts.phase == PH_0) |-> (front_sts.held == 4'd0))
    else $error("held bits at group start");

  // A request is never popped from an empty queue
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

/* dv/xob64_char_checker.sv */
`default_nettype none

// Watches both channels, predicts the Base64 text of every accepted request
// and compares each delivered character against the oldest prediction.
module xob64_char_checker
  import xob64_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  xob64_in_if       in_ch,
  xob64_out_if      out_ch,
  output int        mismatch_cnt,
  output int        chars_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  // Standard alphabet, sextet 0 in the top byte
  localparam logic [511:0] B64_ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct packed {
    logic [7:0] code;
    logic       is_last;
  } enc_char_t;

  enc_char_t  expected_chars[$];
  logic [3:0] held_bits;
  logic [1:0] group_phase;

  initial begin
    mismatch_cnt  = 0;
    chars_pending = 0;
    held_bits     = '0;
    group_phase   = PH_0;
  end

  function automatic logic [7:0] sextet_ascii(input logic [5:0] s);
    return B64_ALPHABET[8*(63-s) +: 8];
  endfunction

  // Encode one request into 1..4 characters and advance the group state
  task automatic predict_chars(input logic [7:0] plain, input logic fin);
    logic [7:0] ob;
    enc_char_t  grp[$];
    ob = ~plain ^ OBF_MASK;
    case (group_phase)
      PH_1: begin
        grp.insert(grp.size(), enc_char_t'{sextet_ascii({held_bits[1:0], ob[7:4]}), 1'b0});
        held_bits   = ob[3:0];
        group_phase = PH_2;
      end
      PH_2: begin
        grp.insert(grp.size(), enc_char_t'{sextet_ascii({held_bits, ob[7:6]}), 1'b0});
        grp.insert(grp.size(), enc_char_t'{sextet_ascii(ob[5:0]), 1'b0});
        held_bits   = '0;
        group_phase = PH_0;
      end
      default: begin
        // unused phase behaves like the start of a group
        grp.insert(grp.size(), enc_char_t'{sextet_ascii(ob[7:2]), 1'b0});
        held_bits   = {2'b00, ob[1:0]};
        group_phase = PH_1;
      end
    endcase

    // last byte: flush leftover bits, pad to a full group
    if (fin) begin
      if (group_phase == PH_1) begin
        grp.insert(grp.size(), enc_char_t'{sextet_ascii({held_bits[1:0], 4'b0000}), 1'b0});
        grp.insert(grp.size(), enc_char_t'{PAD_CHAR, 1'b0});
        grp.insert(grp.size(), enc_char_t'{PAD_CHAR, 1'b0});
      end else if (group_phase == PH_2) begin
        grp.insert(grp.size(), enc_char_t'{sextet_ascii({held_bits, 2'b00}), 1'b0});
        grp.insert(grp.size(), enc_char_t'{PAD_CHAR, 1'b0});
      end
      grp[grp.size()-1].is_last = 1'b1;
      held_bits   = '0;
      group_phase = PH_0;
    end

    foreach (grp[i]) expected_chars.insert(expected_chars.size(), grp[i]);
  endtask

  // Outputs first: a character delivered this edge is never from this edge's request
  always @(posedge clk) begin
    enc_char_t want;
    if (!rst_n) begin
      held_bits   = '0;
      group_phase = PH_0;
      expected_chars.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_chars.size() == 0) begin
          mismatch_cnt++;
          $display("%0t: unexpected char: expected none, actual %h last %b",
                   $time, out_ch.out_char, out_ch.final_char);
        end else begin
          want = expected_chars.pop_front();
          if (out_ch.out_char !== want.code) begin
            mismatch_cnt++;
            $display("%0t: out_char mismatch: expected %h, actual %h",
                     $time, want.code, out_ch.out_char);
          end
          if (out_ch.final_char !== want.is_last) begin
            mismatch_cnt++;
            $display("%0t: final_char mismatch: expected %b, actual %b",
                     $time, want.is_last, out_ch.final_char);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        predict_chars(in_ch.data_byte, in_ch.final_byte);
      end
    end
    chars_pending = expected_chars.size();
  end

endmodule

`default_nettype wire

/* dv/tb.sv */
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_BYTES = 21;
  localparam int N_DIRECTED  = 17;

  // {final_byte, data_byte}: single-byte messages, two- and three-byte
  // messages, sextets 0, 62 and 63, a message ending mid-group
  localparam logic [8:0] DIRECTED_REQS [N_DIRECTED] = '{
    {1'b1, 8'h00},
    {1'b1, 8'hFF},
    {1'b0, 8'h55}, {1'b1, 8'hAA},
    {1'b0, 8'hAA}, {1'b0, 8'h55}, {1'b1, 8'h00},
    {1'b0, 8'hAD}, {1'b0, 8'h12}, {1'b0, 8'h34}, {1'b1, 8'hFE},
    {1'b0, 8'hFF}, {1'b0, 8'hFF}, {1'b0, 8'hFF},
    {1'b0, 8'h00}, {1'b0, 8'h00}, {1'b1, 8'h00}
  };

  // Idle percentages per random phase: none, sender, receiver, both
  localparam int SEND_IDLE [4] = '{0, 53, 0, 22};
  localparam int RECV_STALL [4] = '{0, 0, 53, 22};

  logic clk;
  logic rst_n;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  int   cycle_cnt      = 0;
  int   mismatch_cnt;
  int   chars_pending;

  xob64_in_if  in_ch ();
  xob64_out_if out_ch ();

  xor_obfuscate_base64_encoder uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch.sink),
    .out_if (out_ch.source)
  );

  xob64_char_checker chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .mismatch_cnt  (mismatch_cnt),
    .chars_pending (chars_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // valid stays high between back-to-back requests
  task automatic send_byte(input logic [7:0] d, input logic fin);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.data_byte  <= d;
    in_ch.final_byte <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Sender holds off until every predicted character has been delivered
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
  endtask

  initial begin
    int len;
    int sent;
    in_ch.valid      = 1'b0;
    in_ch.data_byte  = '0;
    in_ch.final_byte = 1'b0;
    out_ch.ready     = 1'b0;
    rst_n            = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed messages, no idling
    foreach (DIRECTED_REQS[i]) send_byte(DIRECTED_REQS[i][7:0], DIRECTED_REQS[i][8]);
    wait_drained();

    // random messages, whole messages per idling phase
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = SEND_IDLE[p];
      recv_stall_pct = RECV_STALL[p];
      sent = 0;
      while (sent < PHASE_BYTES) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(6, 1);
        // keep the phase at its byte budget
        if (len > PHASE_BYTES - sent) len = PHASE_BYTES - sent;
        for (int k = 0; k < len; k++) begin
          send_byte(8'($urandom_range(255)), k == len - 1);
        end
        sent += len;
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
rtl/core/xob64_pkg.sv
rtl/core/xob64_ifs.sv
rtl/core/xob64_front.sv
rtl/core/xob64_fifo.sv
rtl/core/xob64_back.sv
rtl/core/xor_obfuscate_base64_encoder.sv
dv/xob64_char_checker.sv
dv/tb.sv
